[hw/rtl/fmv_pkg.sv]
// Shared constants, step codes and controller/datapath interface types of the FM voice mixer.
package fmv_pkg;

  localparam int VOICE_COUNT     = 16;
  localparam int SINE_TABLE_BITS = 10;
  localparam int PHASE_BITS      = 32;

  localparam int VIDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int QBITS  = SINE_TABLE_BITS - 2;
  localparam int SUM_W  = 18 + $clog2(VOICE_COUNT);
  localparam int OP_W   = SUM_W + 16;
  localparam int MS_W   = PHASE_BITS + 16;

  localparam logic [16:0] ENV_ONE   = 17'd65536;
  localparam logic [16:0] ENV_STOP  = 17'd132;
  localparam logic [16:0] SIN_A1    = 17'd102944;
  localparam logic [16:0] SIN_B3    = 17'd42166;
  localparam logic [16:0] SIN_A5    = 17'd4758;
  localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
  localparam logic [17:0] RECIP_127 = 18'd132104;
  localparam logic [14:0] OUT_GAIN  = 15'd22938;

  localparam logic [1:0] CFG_MOD_INDEX   = 2'd0;
  localparam logic [1:0] CFG_MOD_RATIO   = 2'd1;
  localparam logic [1:0] CFG_ATTACK_COEF = 2'd2;
  localparam logic [1:0] CFG_DECAY_COEF  = 2'd3;

  typedef enum logic [4:0] {
    DP_NONE, DP_ENV, DP_MSTEP, DP_SIN_MOD, DP_SIN_CAR, DP_SIN_SQ, DP_SIN_IN,
    DP_SIN_MID, DP_SIN_FIN, DP_OFF1, DP_OFF2, DP_OFF3, DP_TRM1, DP_TRM2,
    DP_TRM3, DP_TRM4, DP_OUT1, DP_OUT2
  } dp_step_t;

  typedef struct packed {
    dp_step_t          step;
    logic [VIDX_W-1:0] vidx;
    logic              wr_en;
    logic              cfg_en;
    logic              clr_sum;
  } dp_cmd_t;

  typedef struct packed {
    logic voice_active;
    logic voice_stop;
  } dp_stat_t;

endpackage

[hw/rtl/fmv_ctrl.sv]
// Sequencer of the FM voice mixer: walks the voices and issues datapath steps.
module fmv_ctrl import fmv_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_command,
  output logic     in_ready,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_ENV, S_MSTEP,
    S_M_U, S_M_SQ, S_M_IN, S_M_MID, S_M_FIN,
    S_OFF1, S_OFF2, S_OFF3,
    S_C_U, S_C_SQ, S_C_IN, S_C_MID, S_C_FIN,
    S_TRM1, S_TRM2, S_TRM3, S_TRM4,
    S_OUT1, S_OUT2
  } state_t;

  state_t            state_r, state_nxt;
  logic [VIDX_W-1:0] vidx_r, vidx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              last_voice;
  logic              load_out;
  dp_step_t          step;

  assign in_ready   = (state_r == S_IDLE);
  assign cfg_ready  = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign last_voice = (vidx_r == VIDX_W'(VOICE_COUNT - 1));
  assign load_out   = (state_r == S_OUT2) && (!out_valid_r || out_ready);

  assign cmd.step    = step;
  assign cmd.vidx    = vidx_r;
  assign cmd.wr_en   = in_valid && in_ready && in_command;
  assign cmd.cfg_en  = cfg_valid && cfg_ready;
  assign cmd.clr_sum = in_valid && in_ready && !in_command;

  always_comb begin
    case (state_r)
      S_ENV:                  step = DP_ENV;
      S_MSTEP:                step = DP_MSTEP;
      S_M_U:                  step = DP_SIN_MOD;
      S_C_U:                  step = DP_SIN_CAR;
      S_M_SQ, S_C_SQ:         step = DP_SIN_SQ;
      S_M_IN, S_C_IN:         step = DP_SIN_IN;
      S_M_MID, S_C_MID:       step = DP_SIN_MID;
      S_M_FIN, S_C_FIN:       step = DP_SIN_FIN;
      S_OFF1:                 step = DP_OFF1;
      S_OFF2:                 step = DP_OFF2;
      S_OFF3:                 step = DP_OFF3;
      S_TRM1:                 step = DP_TRM1;
      S_TRM2:                 step = DP_TRM2;
      S_TRM3:                 step = DP_TRM3;
      S_TRM4:                 step = DP_TRM4;
      S_OUT1:                 step = DP_OUT1;
      S_OUT2:                 step = load_out ? DP_OUT2 : DP_NONE;
      default:                step = DP_NONE;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    vidx_nxt      = vidx_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (cmd.clr_sum) begin
          vidx_nxt  = '0;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.voice_active) begin
          state_nxt = S_ENV;
        end else if (last_voice) begin
          state_nxt = S_OUT1;
        end else begin
          vidx_nxt = vidx_r + 1'b1;
        end
      end
      S_ENV: begin
        if (!stat.voice_stop) begin
          state_nxt = S_MSTEP;
        end else if (last_voice) begin
          state_nxt = S_OUT1;
        end else begin
          vidx_nxt  = vidx_r + 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_MSTEP: state_nxt = S_M_U;
      S_M_U:   state_nxt = S_M_SQ;
      S_M_SQ:  state_nxt = S_M_IN;
      S_M_IN:  state_nxt = S_M_MID;
      S_M_MID: state_nxt = S_M_FIN;
      S_M_FIN: state_nxt = S_OFF1;
      S_OFF1:  state_nxt = S_OFF2;
      S_OFF2:  state_nxt = S_OFF3;
      S_OFF3:  state_nxt = S_C_U;
      S_C_U:   state_nxt = S_C_SQ;
      S_C_SQ:  state_nxt = S_C_IN;
      S_C_IN:  state_nxt = S_C_MID;
      S_C_MID: state_nxt = S_C_FIN;
      S_C_FIN: state_nxt = S_TRM1;
      S_TRM1:  state_nxt = S_TRM2;
      S_TRM2:  state_nxt = S_TRM3;
      S_TRM3:  state_nxt = S_TRM4;
      S_TRM4: begin
        if (last_voice) begin
          state_nxt = S_OUT1;
        end else begin
          vidx_nxt  = vidx_r + 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_OUT1:  state_nxt = S_OUT2;
      S_OUT2: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vidx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vidx_r      <= vidx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[hw/rtl/fmv_datapath.sv]
// Voice state, configuration registers and the stepped arithmetic of the FM voice mixer.
module fmv_datapath import fmv_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  dp_cmd_t                  cmd,
  output dp_stat_t                 stat,
  input  logic [3:0]               in_voice_index,
  input  logic [31:0]              in_phase_step,
  input  logic [6:0]               in_velocity,
  input  logic                     in_voice_active,
  input  logic                     in_releasing,
  input  logic                     in_clear_phase,
  input  logic [1:0]               cfg_index,
  input  logic [15:0]              cfg_data,
  output logic signed [19:0]       out_sample
);

  logic [PHASE_BITS-1:0] car_ph_r   [VOICE_COUNT];
  logic [PHASE_BITS-1:0] mod_ph_r   [VOICE_COUNT];
  logic [PHASE_BITS-1:0] car_step_r [VOICE_COUNT];
  logic [16:0]           env_mem_r  [VOICE_COUNT];
  logic [6:0]            vel_mem_r  [VOICE_COUNT];
  logic [VOICE_COUNT-1:0] act_r, rel_r;

  logic [15:0] mod_index_r, mod_ratio_r, attack_r, decay_r;

  logic [16:0]           env_r, u_r, u2_r, inner_r, mid_r;
  logic [14:0]           mag_r;
  logic                  sneg_r;
  logic [PHASE_BITS-1:0] mstep_r, off_r;
  logic [32:0]           a_r, b_r;
  logic [31:0]           t1_r;
  logic [23:0]           y_r;
  logic [17:0]           q0_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0]      om_r;
  logic                  oneg_r;
  logic signed [19:0]    sample_r;

  logic [VIDX_W-1:0]     idx, widx;
  logic                  wr_ok;
  logic [16:0]           env_cur, env_new;
  logic [32:0]           rel_prod, att_prod;
  logic [PHASE_BITS-1:0] sin_ph;
  logic [SINE_TABLE_BITS-1:0] tidx;
  logic [QBITS:0]        pos;
  logic [33:0]           sq_prod, in_prod, mid_prod, fin_prod;
  logic [17:0]           rr;
  logic [16:0]           half;
  logic [47:0]           b_prod;
  logic [62:0]           d_prod;
  logic [PHASE_BITS-1:0] offm;
  logic [MS_W-1:0]       ms_prod;
  logic [38:0]           y_prod;
  logic [41:0]           q_prod;
  logic [24:0]           rem;
  logic [17:0]           term;
  logic [SUM_W-1:0]      absum;
  logic [OP_W-1:0]       o_prod;

  assign idx     = cmd.vidx;
  assign widx    = VIDX_W'(in_voice_index);
  assign wr_ok   = cmd.wr_en && (32'(in_voice_index) < VOICE_COUNT);
  assign env_cur = env_mem_r[idx];

  // Envelope: release multiplies by the decay factor, attack closes the gap to one.
  assign rel_prod = 33'(env_cur) * 33'(decay_r);
  assign att_prod = 33'(ENV_ONE - env_cur) * 33'(attack_r);
  always_comb begin
    if (rel_r[idx]) begin
      env_new = rel_prod[32:16];
    end else if (env_cur < ENV_ONE) begin
      env_new = ENV_ONE - att_prod[32:16];
    end else begin
      env_new = env_cur;
    end
  end

  assign stat.voice_active = act_r[idx];
  assign stat.voice_stop   = rel_r[idx] && (env_new < ENV_STOP);

  // Quarter-wave fold of the table index.
  assign sin_ph = (cmd.step == DP_SIN_CAR) ? car_ph_r[idx] + off_r : mod_ph_r[idx];
  assign tidx   = sin_ph[PHASE_BITS-1 -: SINE_TABLE_BITS];
  assign pos    = tidx[QBITS] ? (QBITS+1)'(1 << QBITS) - {1'b0, tidx[QBITS-1:0]}
                              : {1'b0, tidx[QBITS-1:0]};

  assign sq_prod  = 34'(u_r) * 34'(u_r);
  assign in_prod  = 34'(SIN_A5) * 34'(u2_r);
  assign mid_prod = 34'(u2_r) * 34'(inner_r);
  assign fin_prod = 34'(u_r) * 34'(mid_r);
  assign rr       = fin_prod[33:16] + 18'd1;
  assign half     = rr[17:1];

  assign b_prod  = 48'(a_r) * 48'(mag_r);
  assign d_prod  = 63'(b_r) * 63'(INV_TWO_PI_Q32);
  assign offm    = d_prod[56-PHASE_BITS +: PHASE_BITS];
  assign ms_prod = MS_W'(car_step_r[idx]) * MS_W'(mod_ratio_r);

  assign y_prod = 39'(t1_r) * 39'(vel_mem_r[idx]);
  assign q_prod = 42'(y_r) * 42'(RECIP_127);
  assign rem    = {1'b0, y_r} - ({q0_r, 7'b0} - 25'(q0_r));
  assign term   = (rem >= 25'd127) ? q0_r + 18'd1 : q0_r;

  assign absum  = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign o_prod = OP_W'(absum) * OP_W'(OUT_GAIN) + OP_W'(32768);

  assign out_sample = sample_r;

  // Voice state and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int v = 0; v < VOICE_COUNT; v++) begin
        car_ph_r[v]   <= '0;
        mod_ph_r[v]   <= '0;
        car_step_r[v] <= '0;
        env_mem_r[v]  <= '0;
        vel_mem_r[v]  <= '0;
      end
      act_r       <= '0;
      rel_r       <= '0;
      mod_index_r <= 16'd256;
      mod_ratio_r <= 16'd256;
      attack_r    <= 16'd65000;
      decay_r     <= 16'd65500;
    end else begin
      if (cmd.cfg_en) begin
        case (cfg_index)
          CFG_MOD_INDEX:   mod_index_r <= cfg_data;
          CFG_MOD_RATIO:   mod_ratio_r <= cfg_data;
          CFG_ATTACK_COEF: attack_r    <= cfg_data;
          CFG_DECAY_COEF:  decay_r     <= cfg_data;
          default:         mod_index_r <= mod_index_r;
        endcase
      end
      if (wr_ok) begin
        car_step_r[widx] <= in_phase_step[PHASE_BITS-1:0];
        vel_mem_r[widx]  <= in_velocity;
        act_r[widx]      <= in_voice_active;
        rel_r[widx]      <= in_releasing;
        if (in_clear_phase) begin
          car_ph_r[widx]  <= '0;
          mod_ph_r[widx]  <= '0;
          env_mem_r[widx] <= '0;
        end
      end
      case (cmd.step)
        DP_ENV: begin
          env_mem_r[idx] <= env_new;
          if (stat.voice_stop) begin
            act_r[idx] <= 1'b0;
          end
        end
        DP_OFF3:    mod_ph_r[idx] <= mod_ph_r[idx] + mstep_r;
        DP_SIN_CAR: car_ph_r[idx] <= car_ph_r[idx] + car_step_r[idx];
        default: ;
      endcase
    end
  end

  // Working registers of the stepped arithmetic.
  always_ff @(posedge clk) begin
    if (cmd.clr_sum) begin
      sum_r <= '0;
    end
    case (cmd.step)
      DP_ENV:     env_r <= env_new;
      DP_MSTEP:   mstep_r <= ms_prod[8 +: PHASE_BITS];
      DP_SIN_MOD, DP_SIN_CAR: begin
        u_r    <= {pos, {(16-QBITS){1'b0}}};
        sneg_r <= tidx[SINE_TABLE_BITS-1];
      end
      DP_SIN_SQ:  u2_r    <= sq_prod[32:16];
      DP_SIN_IN:  inner_r <= SIN_B3 - in_prod[32:16];
      DP_SIN_MID: mid_r   <= SIN_A1 - mid_prod[32:16];
      DP_SIN_FIN: mag_r   <= (half > 17'd32767) ? 15'd32767 : half[14:0];
      DP_OFF1:    a_r <= 33'(mod_index_r) * 33'(env_r);
      DP_OFF2:    b_r <= b_prod[47:15];
      DP_OFF3:    off_r <= sneg_r ? PHASE_BITS'(0) - offm : offm;
      DP_TRM1:    t1_r <= 32'(mag_r) * 32'(env_r);
      DP_TRM2:    y_r <= y_prod[38:15];
      DP_TRM3:    q0_r <= q_prod[41:24];
      DP_TRM4: begin
        if (sneg_r) begin
          sum_r <= sum_r - signed'(SUM_W'(term));
        end else begin
          sum_r <= sum_r + signed'(SUM_W'(term));
        end
      end
      DP_OUT1: begin
        om_r   <= o_prod[16 +: SUM_W];
        oneg_r <= sum_r[SUM_W-1];
      end
      DP_OUT2: begin
        if (!oneg_r) begin
          sample_r <= (om_r > SUM_W'(524287)) ? 20'sd524287 : signed'(20'(om_r));
        end else begin
          sample_r <= (om_r > SUM_W'(524288)) ? -20'sd524288 : signed'(20'(-om_r));
        end
      end
      default: ;
    endcase
  end

endmodule

[hw/rtl/fm_two_operator_voice_mixer.sv]
// Top level of the sixteen-voice two-operator FM voice mixer.
//
// Usage:
//   in_*  : one beat is either a voice write (in_command = 1) or a tick
//           (in_command = 0). A voice write loads one voice in the cycle it
//           is taken and returns nothing. A tick renders one mono sample.
//   out_* : one beat per tick, out_sample signed Q3.16, saturated.
//   cfg_* : writes mod_index, mod_ratio, attack_coef, decay_coef by index.
//           The modulator step is derived from the carrier step and the
//           current ratio on every tick, so a ratio write acts at once.
// Timing: a tick walks the voices in turn: a silent voice is skipped, a voice
//   whose release ends stops after its envelope step, and a sounding voice
//   runs one shared sequence of single-multiply steps (two sine polynomials,
//   modulation offset, voice gain). The output steps then close the tick.
// Reset: all voices silent with zero phases, steps and envelopes; config
//   registers take their default values; no result pending.
// Stall: the finished sample holds in the output register; a new beat is
//   taken meanwhile, but a tick completing behind an untaken sample waits.
module fm_two_operator_voice_mixer import fmv_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_command,
  input  logic [3:0]         in_voice_index,
  input  logic [31:0]        in_phase_step,
  input  logic [6:0]         in_velocity,
  input  logic               in_voice_active,
  input  logic               in_releasing,
  input  logic               in_clear_phase,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [19:0] out_sample,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequence the voice walk and own every handshake.
  fmv_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_ready   (in_ready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Hold voice state and compute one step per cycle, except while a finished tick waits on an untaken sample.
  fmv_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_voice_index  (in_voice_index),
    .in_phase_step   (in_phase_step),
    .in_velocity     (in_velocity),
    .in_voice_active (in_voice_active),
    .in_releasing    (in_releasing),
    .in_clear_phase  (in_clear_phase),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_sample      (out_sample)
  );

endmodule
